// ===== hdl/pee_pkg.sv =====
package pee_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int WORD_W      = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_DIVZERO   = 3'd2;
  localparam logic [2:0] ST_BADOP     = 3'd3;
  localparam logic [2:0] ST_LEFTOVER  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  typedef enum logic [2:0] {
    OP_DIGIT = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_BAD   = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [2:0]       err;
  } bk_stat_t;

endpackage

// ===== hdl/pee_front.sv =====
module pee_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     in_ch,
  input  logic           in_last,
  input  logic           in_push,
  output logic           in_full,
  output pee_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_take
);
  import pee_pkg::*;

  item_t              dec;
  item_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_r, rptr_r;
  logic [Q_PTR_W:0]   fill_r;
  logic               wr, rd;

  always_comb begin
    dec.last  = in_last;
    dec.digit = 4'(in_ch - CH_ZERO);
    if (in_ch >= CH_ZERO && in_ch <= CH_NINE) begin
      dec.op = OP_DIGIT;
    end else begin
      unique case (in_ch)
        CH_PLUS:  dec.op = OP_ADD;
        CH_MINUS: dec.op = OP_SUB;
        CH_STAR:  dec.op = OP_MUL;
        CH_SLASH: dec.op = OP_DIV;
        default:  dec.op = OP_BAD;
      endcase
    end
  end

  assign in_full = (fill_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_item  = slot_r[rptr_r];
  assign wr      = in_push && !in_full;
  assign rd      = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (wr) wptr_r <= wptr_r + 1'b1;
      if (rd) rptr_r <= rptr_r + 1'b1;
      case ({wr, rd})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ===== hdl/pee_divider.sv =====
module pee_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pee_pkg::WORD_W-1:0] dividend,
  input  logic [pee_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [pee_pkg::WORD_W-1:0] quotient
);
  import pee_pkg::*;

  localparam int STEP_W = $clog2(WORD_W);

  logic [WORD_W-1:0] dvd_r, dvs_r, rem_r;
  logic [WORD_W:0]   trial, diff;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r, neg_r, fit;

  assign trial = {rem_r, dvd_r[WORD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fit   = !diff[WORD_W];

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_r <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
      rem_r <= '0;
      neg_r <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy_r) begin
      rem_r <= fit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      dvd_r <= {dvd_r[WORD_W-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(WORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~dvd_r + 1'b1) : dvd_r;

endmodule

// ===== hdl/pee_back.sv =====
module pee_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pee_pkg::item_t             q_item,
  input  logic                       q_valid,
  output logic                       q_take,
  output logic                       div_start,
  output logic [pee_pkg::WORD_W-1:0] div_a,
  output logic [pee_pkg::WORD_W-1:0] div_b,
  input  logic                       div_done,
  input  logic [pee_pkg::WORD_W-1:0] div_q,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [pee_pkg::WORD_W-1:0] out_value,
  output logic [2:0]                 out_status,
  output pee_pkg::bk_stat_t          stat
);
  import pee_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_HOLD = 5'b10000
  } bst_t;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data_r, tos_r, tos_nxt, sum, dif;
  logic [2*WORD_W-1:0] prod;
  logic [CNT_W-1:0]  count_r, count_nxt, cnt_m1, cnt_m2;
  logic [2:0]        err_r, err_nxt;
  bst_t              state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic              last_r, last_nxt;
  logic              mem_we, mem_re;
  logic              out_valid_r, out_load;
  logic [WORD_W-1:0] out_value_r, fin_value;
  logic [2:0]        out_status_r, fin_status;

  assign cnt_m1 = count_r - 1'b1;
  assign cnt_m2 = count_r - 2'd2;
  assign sum    = rd_data_r + tos_r;
  assign dif    = rd_data_r - tos_r;
  assign prod   = rd_data_r * tos_r;
  assign div_a  = rd_data_r;
  assign div_b  = tos_r;

  always_comb begin
    fin_value  = '0;
    fin_status = err_r;
    if (err_r == ST_OK) begin
      if (count_r == '0) begin
        fin_status = ST_UNDERFLOW;
      end else if (count_r != CNT_W'(1)) begin
        fin_status = ST_LEFTOVER;
      end else begin
        fin_value = tos_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    tos_nxt   = tos_r;
    op_nxt    = op_r;
    last_nxt  = last_r;
    q_take    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_take   = 1'b1;
          op_nxt   = q_item.op;
          last_nxt = q_item.last;
          state_nxt = q_item.last ? S_FIN : S_IDLE;
          if (err_r == ST_OK) begin
            if (q_item.op == OP_DIGIT) begin
              if (count_r == FULL_CNT) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                mem_we    = (count_r != '0);
                tos_nxt   = {{(WORD_W-4){1'b0}}, q_item.digit};
                count_nxt = count_r + 1'b1;
              end
            end else if (count_r < CNT_W'(2)) begin
              err_nxt = ST_UNDERFLOW;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_EXEC;
            end
          end
        end
      end
      S_EXEC: begin
        state_nxt = last_r ? S_FIN : S_IDLE;
        count_nxt = cnt_m1;
        case (op_r)
          OP_ADD: tos_nxt = sum;
          OP_SUB: tos_nxt = dif;
          OP_MUL: tos_nxt = prod[WORD_W-1:0];
          OP_DIV: begin
            if (tos_r == '0) begin
              err_nxt = ST_DIVZERO;
            end else begin
              div_start = 1'b1;
              count_nxt = count_r;
              state_nxt = S_DIV;
            end
          end
          default: err_nxt = ST_BADOP;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          tos_nxt   = div_q;
          count_nxt = cnt_m1;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_pop) begin
          out_load  = 1'b1;
          count_nxt = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_pop) begin
          out_load  = 1'b1;
          count_nxt = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_m1[ADDR_W-1:0]] <= tos_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[cnt_m2[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    tos_r  <= tos_nxt;
    op_r   <= op_nxt;
    last_r <= last_nxt;
    if (out_load) begin
      out_value_r  <= fin_value;
      out_status_r <= fin_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty  = !out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign stat.count = count_r;
  assign stat.err   = err_r;

endmodule

// ===== hdl/postfix_expression_evaluator.sv =====
// Postfix expression evaluator. Characters go in one per transfer, with in_last set on the
// final one; that character yields exactly one result (out_value, out_status) and clears the
// stack for the next expression. A front decoder feeds a four-entry queue, so in_full only
// rises once the back end falls behind. The back end takes a digit directly; + - * and an
// unknown character first do a registered read of the second operand from the stack RAM
// and then an execute step when two operands are present, else they are taken directly;
// / also waits in a divide state for the 32-step radix-2 divider, unless the execute step
// finds a zero divisor; while an error is pending every character is taken directly. The
// final character then passes a finish state that loads the result register, or a hold state
// while the previous result waits to be popped. No clearing pass is needed after reset.
module postfix_expression_evaluator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 in_ch,
  input  logic                       in_last,
  input  logic                       in_push,
  output logic                       in_full,
  output logic signed [31:0]         out_value,
  output logic [2:0]                 out_status,
  output logic                       out_empty,
  input  logic                       out_pop
);
  import pee_pkg::*;

  item_t             q_item;
  logic              q_valid, q_take;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_a, div_b, div_q, value;
  bk_stat_t          stat;

  pee_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .in_last (in_last),
    .in_push (in_push),
    .in_full (in_full),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_take  (q_take)
  );

  pee_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  pee_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_take     (q_take),
    .div_start  (div_start),
    .div_a      (div_a),
    .div_b      (div_b),
    .div_done   (div_done),
    .div_q      (div_q),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_value  (value),
    .out_status (out_status),
    .stat       (stat)
  );

  assign out_value = $signed(value);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |-> (out_value == '0))
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status <= ST_OVERFLOW))
    else $error("status code out of range");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_value) && $stable(out_status)))
    else $error("waiting result changed before transfer");

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pee_pkg::*;

  localparam int N_RANDOM   = 1600;
  localparam int LIMIT      = 600000;
  localparam int LONG_HOLD  = 400;
  localparam int TAIL_WAIT  = 60;
  localparam int MAX_REPORT = 10;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } rpn_char_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  status;
  } rpn_answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic [7:0]         in_ch = '0;
  logic               in_last = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic signed [31:0] out_value;
  logic [2:0]         out_status;
  logic               out_empty;
  logic               out_pop = 1'b0;

  postfix_expression_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .in_last    (in_last),
    .in_push    (in_push),
    .in_full    (in_full),
    .out_value  (out_value),
    .out_status (out_status),
    .out_empty  (out_empty),
    .out_pop    (out_pop)
  );

  rpn_char_t   char_q[$];
  rpn_answer_t answer_q[$];

  logic [31:0] stk [STACK_DEPTH];
  int          depth = 0;
  logic [2:0]  err = ST_OK;

  int  errors = 0;
  int  cycles = 0;
  int  n_items = 0;
  bit  drain_next = 1'b0;

  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  gap_left = 0;
  bit  send_burst = 1'b0;
  int  stall_left = 0;
  bit  recv_burst = 1'b0;
  int  n_taken = 0;

  rpn_char_t   cur;
  rpn_answer_t got;
  int          stall;

  initial begin
    forever #10 clk = ~clk;
  end

  // expression evaluation on the stack copy, one character per transfer
  task automatic rpn_step(input logic [7:0] c, input logic fin);
    logic [31:0] a, b, r;
    longint      q;
    rpn_answer_t ans;
    if (err == ST_OK) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (depth >= STACK_DEPTH) begin
          err = ST_OVERFLOW;
        end else begin
          stk[depth] = {24'd0, c - CH_ZERO};
          depth++;
        end
      end else if (depth < 2) begin
        err = ST_UNDERFLOW;
      end else begin
        b = stk[depth-1];
        a = stk[depth-2];
        depth -= 2;
        r = '0;
        case (c)
          CH_PLUS:  r = a + b;
          CH_MINUS: r = a - b;
          CH_STAR:  r = a * b;
          CH_SLASH: begin
            if (b == '0) begin
              err = ST_DIVZERO;
            end else begin
              q = longint'($signed(a)) / longint'($signed(b));
              r = q[31:0];
            end
          end
          default:  err = ST_BADOP;
        endcase
        if (err == ST_OK) begin
          stk[depth] = r;
          depth++;
        end
      end
    end
    if (fin) begin
      ans.status = err;
      ans.value  = '0;
      if (err == ST_OK) begin
        if (depth == 0) ans.status = ST_UNDERFLOW;
        else if (depth > 1) ans.status = ST_LEFTOVER;
        else ans.value = stk[0];
      end
      answer_q.push_back(ans);
      depth = 0;
      err   = ST_OK;
    end
  endtask

  task automatic put_char(input logic [7:0] c);
    rpn_char_t it;
    it.ch    = c;
    it.last  = 1'b0;
    it.drain = drain_next;
    drain_next = 1'b0;
    char_q.push_back(it);
    n_items++;
  endtask

  task automatic end_expr();
    char_q[$].last = 1'b1;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
    end_expr();
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // well-formed expression with n digits; glitch >= 0 swaps that step for a random byte,
  // short_ops leaves operators off the end
  task automatic gen_expr(input int n, input int glitch, input int short_ops);
    int left, d, step;
    left = n;
    d    = 0;
    step = 0;
    while (left > 0 || d > 1 + short_ops) begin
      if (step == glitch) begin
        put_char(8'($urandom_range(0, 255)));
      end else if (left > 0 && (d < 2 || $urandom_range(0, 2) != 0)) begin
        put_char(pick_digit());
        left--;
        d++;
      end else begin
        put_char(pick_op());
        d--;
      end
      step++;
    end
    end_expr();
  endtask

  task automatic gen_deep(input int k, input int n_ops);
    repeat (k) put_char(pick_digit());
    repeat (n_ops) put_char(pick_op());
    end_expr();
  endtask

  // 2 * 8^10 wraps to the most negative word, then divided by 0 - 1
  task automatic gen_min_div();
    put_char(CH_ZERO + 8'd2);
    repeat (10) begin
      put_char(CH_ZERO + 8'd8);
      put_char(CH_STAR);
    end
    put_char(CH_ZERO);
    put_char(CH_ZERO + 8'd1);
    put_char(CH_MINUS);
    put_char(CH_SLASH);
    if ($urandom_range(0, 1)) begin
      put_char(pick_digit());
      put_char(pick_op());
    end
    end_expr();
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 2))
        0:       put_char(8'($urandom_range(0, 255)));
        1:       put_char(pick_digit());
        default: put_char(pick_op());
      endcase
    end
    end_expr();
  endtask

  task automatic report(input rpn_answer_t e, input bit have_exp);
    errors++;
    if (errors <= MAX_REPORT) begin
      if (have_exp)
        $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                 $signed(e.value), e.status, out_value, out_status);
      else
        $display("unexpected result: value %0d status %0d", out_value, out_status);
    end
  endtask

  initial begin
    int r, base;
    put_text("9");
    put_text("56+");
    put_text("08-");
    put_text("78*");
    put_text("93/");
    put_text("50/");
    put_text("+");
    put_char(CH_ZERO + 8'd1);
    put_char(CH_ZERO + 8'd2);
    put_char(8'h00);
    end_expr();
    put_char(CH_ZERO + 8'd3);
    put_char(8'hff);
    put_char(CH_ZERO + 8'd4);
    end_expr();
    put_text("12");

    base = n_items;
    drain_next = 1'b1;
    gen_min_div();
    gen_deep(STACK_DEPTH, STACK_DEPTH - 1);
    gen_deep(STACK_DEPTH + 1, 2);
    while (n_items - base < N_RANDOM) begin
      if ($urandom_range(0, 59) == 0) drain_next = 1'b1;
      r = $urandom_range(0, 199);
      if (r < 3)       gen_deep($urandom_range(56, STACK_DEPTH), $urandom_range(50, 55));
      else if (r < 5)  gen_deep($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4), 3);
      else if (r < 8)  gen_min_div();
      else if (r < 40) gen_noise();
      else if (r < 55) gen_expr($urandom_range(2, 8), $urandom_range(0, 8), 0);
      else if (r < 65) gen_expr($urandom_range(2, 8), -1, $urandom_range(1, 2));
      else             gen_expr($urandom_range(1, 8), -1, 0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || in_push) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("postfix_expression_evaluator test passed");
    end else begin
      $display("postfix_expression_evaluator test failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("postfix_expression_evaluator test failed");
      $finish;
    end
  end

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    in_taken  <= rst_n && in_push && !in_full;
    out_taken <= rst_n && out_pop && !out_empty;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (answer_q.size() == 0) begin
          report(got, 1'b0);
        end else begin
          got = answer_q.pop_front();
          if (got.value !== out_value || got.status !== out_status) report(got, 1'b1);
        end
      end
      if (in_push && !in_full) rpn_step(in_ch, in_last);
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_push && !in_taken) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_push  <= 1'b0;
      end else if (char_q.size() != 0 && !(char_q[0].drain && answer_q.size() != 0)) begin
        cur = char_q.pop_front();
        in_ch   <= cur.ch;
        in_last <= cur.last;
        in_push <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
        gap_left <= send_burst ? 0 : $urandom_range(0, 9);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver; a long hold after a few results lets the block fill and stall its input
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_taken) begin
      end else if (out_taken) begin
        n_taken <= n_taken + 1;
        if ($urandom_range(0, 29) == 0) recv_burst <= !recv_burst;
        if (n_taken == 30 || n_taken == 150) stall = LONG_HOLD;
        else stall = recv_burst ? 0 : $urandom_range(0, 9);
        if (stall == 0) begin
          out_pop <= 1'b1;
        end else begin
          out_pop    <= 1'b0;
          stall_left <= stall - 1;
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_pop    <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

endmodule
